>>> rtl/core/lpts_pkg.sv
// Shared types and constants for the preemptive LIFO task scheduler.
package lpts_pkg;

  localparam int IdW    = 10;
  localparam int StartW = 11;
  localparam int RemW   = 12;
  localparam int EndW   = 13;
  localparam int StatW  = 2;
  localparam int EntryW = IdW + RemW;

  localparam logic [StatW-1:0] StatDone     = 2'd0;
  localparam logic [StatW-1:0] StatOverflow = 2'd1;
  localparam logic [StatW-1:0] StatOrder    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_POP,
    ST_DRAIN_CUR,
    ST_DRAIN_POP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [RemW-1:0] rem;
  } entry_t;

endpackage

>>> rtl/core/lpts_stack_mem.sv
// Paused-task stack storage: one write port, one registered read port.
module lpts_stack_mem #(
  parameter int Depth = 31,
  parameter int AddrW = 5
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  lpts_pkg::entry_t      wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output lpts_pkg::entry_t      rdata_o
);

  lpts_pkg::entry_t mem_q [Depth];
  lpts_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lifo_preemptive_task_scheduler_top.sv
// Top level of the preemptive LIFO task scheduler.
//
//  channel | direction | handshake                  | payload
//  input   | in        | in_valid_i / in_stall_o    | task_id, start_minute, duration, last_task
//  output  | out       | out_valid_o / out_stall_i  | done_id, status, run_last
//
// Each accepted task passes through EVAL, then a POP state for each stack entry resumed
// (popped or trimmed) and, on the final task, DRAIN_CUR for the running task and a
// DRAIN_POP state for each stack entry drained, then FIN before the next accept. The
// single read port of the stack memory sets the pop rate. Reset clears the running
// task and the stack count; the stack memory is not cleared. Output stalls hold the
// sequencer once the one-result holding slot and the output register are both full.
module lifo_preemptive_task_scheduler_top #(
  parameter int STACK_DEPTH = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lpts_pkg::IdW-1:0]      task_id_i,
  input  logic [lpts_pkg::StartW-1:0]   start_minute_i,
  input  logic [lpts_pkg::RemW-1:0]     duration_i,
  input  logic                          last_task_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lpts_pkg::IdW-1:0]      done_id_o,
  output logic [lpts_pkg::StatW-1:0]    status_o,
  output logic                          run_last_o
);

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  lpts_pkg::state_e state_q, state_d;

  logic [lpts_pkg::IdW-1:0]    cur_id_q;
  logic [lpts_pkg::RemW-1:0]   cur_rem_q;
  logic [lpts_pkg::StartW-1:0] cur_start_q;
  logic                        cur_valid_q;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [lpts_pkg::StartW-1:0] gap_q, gap_d;

  logic [lpts_pkg::IdW-1:0]    in_id_q;
  logic [lpts_pkg::StartW-1:0] in_start_q;
  logic [lpts_pkg::RemW-1:0]   in_dur_q;
  logic                        in_last_q;

  logic                        hold_v_q;
  logic [lpts_pkg::IdW-1:0]    hold_id_q;
  logic [lpts_pkg::StatW-1:0]  hold_st_q;

  logic                        out_v_q;
  logic [lpts_pkg::IdW-1:0]    out_id_q;
  logic [lpts_pkg::StatW-1:0]  out_st_q;
  logic                        out_last_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        can_emit;
  logic                        go;
  logic                        emit_v;
  logic [lpts_pkg::IdW-1:0]    emit_id;
  logic [lpts_pkg::StatW-1:0]  emit_st;
  logic                        take_new;
  logic                        clear_cur;
  logic                        flush;
  logic                        fin_done;

  logic                        we;
  logic [AddrW-1:0]            waddr;
  lpts_pkg::entry_t            wdata;
  logic                        re;
  logic [AddrW-1:0]            raddr;
  lpts_pkg::entry_t            rdata;

  logic [lpts_pkg::EndW-1:0]   end_w;
  logic [lpts_pkg::EndW-1:0]   start_w;
  logic [lpts_pkg::EndW-1:0]   diff_w;
  logic [lpts_pkg::RemW-1:0]   gap_ext;
  logic [CntW-1:0]             cm1;
  logic [CntW-1:0]             cm2;
  lpts_pkg::state_e            after_st;

  lpts_stack_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != lpts_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_v_q || !out_stall_i;
  assign can_emit   = !hold_v_q || out_free;

  assign end_w   = lpts_pkg::EndW'(cur_start_q) + lpts_pkg::EndW'(cur_rem_q);
  assign start_w = lpts_pkg::EndW'(in_start_q);
  assign diff_w  = end_w - start_w;
  assign gap_ext = lpts_pkg::RemW'(gap_q);
  assign cm1     = cnt_q - CntW'(1);
  assign cm2     = cnt_q - CntW'(2);
  assign after_st = in_last_q ? lpts_pkg::ST_DRAIN_CUR : lpts_pkg::ST_FIN;

  // writes never target an entry in the same cycle it is read; no forwarding needed
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    gap_d     = gap_q;
    emit_v    = 1'b0;
    emit_id   = cur_id_q;
    emit_st   = lpts_pkg::StatDone;
    take_new  = 1'b0;
    clear_cur = 1'b0;
    flush     = 1'b0;
    fin_done  = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q[AddrW-1:0];
    wdata     = '{id: cur_id_q, rem: diff_w[lpts_pkg::RemW-1:0]};
    re        = 1'b0;
    raddr     = cm1[AddrW-1:0];

    unique case (state_q)
      lpts_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = lpts_pkg::ST_EVAL;
        end
      end
      lpts_pkg::ST_EVAL: begin
        state_d = after_st;
        if (cur_valid_q && (in_start_q < cur_start_q)) begin
          emit_v  = 1'b1;
          emit_id = in_id_q;
          emit_st = lpts_pkg::StatOrder;
        end else begin
          take_new = 1'b1;
          if (cur_valid_q) begin
            if (end_w > start_w) begin
              if (cnt_q >= CntW'(STACK_DEPTH)) begin
                emit_v  = 1'b1;
                emit_st = lpts_pkg::StatOverflow;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end else begin
              emit_v = 1'b1;
              gap_d  = lpts_pkg::StartW'(start_w - end_w);
              if ((cnt_q != '0) && (gap_d != '0)) begin
                re      = 1'b1;
                state_d = lpts_pkg::ST_POP;
              end
            end
          end
        end
      end
      lpts_pkg::ST_POP: begin
        state_d = after_st;
        if (gap_ext >= rdata.rem) begin
          emit_v  = 1'b1;
          emit_id = rdata.id;
          cnt_d   = cm1;
          gap_d   = lpts_pkg::StartW'(gap_ext - rdata.rem);
          if ((cnt_q > CntW'(1)) && (gap_ext != rdata.rem)) begin
            re      = 1'b1;
            raddr   = cm2[AddrW-1:0];
            state_d = lpts_pkg::ST_POP;
          end
        end else begin
          we    = 1'b1;
          waddr = cm1[AddrW-1:0];
          wdata = '{id: rdata.id, rem: rdata.rem - gap_ext};
        end
      end
      lpts_pkg::ST_DRAIN_CUR: begin
        emit_v    = cur_valid_q;
        clear_cur = 1'b1;
        if (cnt_q != '0) begin
          re      = 1'b1;
          state_d = lpts_pkg::ST_DRAIN_POP;
        end else begin
          state_d = lpts_pkg::ST_FIN;
        end
      end
      lpts_pkg::ST_DRAIN_POP: begin
        emit_v  = 1'b1;
        emit_id = rdata.id;
        cnt_d   = cm1;
        if (cnt_q > CntW'(1)) begin
          re    = 1'b1;
          raddr = cm2[AddrW-1:0];
        end else begin
          state_d = lpts_pkg::ST_FIN;
        end
      end
      lpts_pkg::ST_FIN: begin
        fin_done = !hold_v_q || out_free;
        flush    = hold_v_q && out_free;
        if (fin_done) begin
          state_d = lpts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpts_pkg::ST_IDLE;
      end
    endcase

    go = !emit_v || can_emit;
    if (!go) begin
      state_d   = state_q;
      cnt_d     = cnt_q;
      gap_d     = gap_q;
      take_new  = 1'b0;
      clear_cur = 1'b0;
      we        = 1'b0;
      re        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpts_pkg::ST_IDLE;
      cur_id_q    <= '0;
      cur_rem_q   <= '0;
      cur_start_q <= '0;
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      gap_q       <= '0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      gap_q   <= gap_d;
      if (take_new) begin
        cur_id_q    <= in_id_q;
        cur_rem_q   <= in_dur_q;
        cur_start_q <= in_start_q;
        cur_valid_q <= 1'b1;
      end else if (clear_cur) begin
        cur_id_q    <= '0;
        cur_rem_q   <= '0;
        cur_start_q <= '0;
        cur_valid_q <= 1'b0;
      end
      if (emit_v && go) begin
        hold_v_q <= 1'b1;
      end else if (flush) begin
        hold_v_q <= 1'b0;
      end
      if ((emit_v && go && hold_v_q) || flush) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_id_q    <= task_id_i;
      in_start_q <= start_minute_i;
      in_dur_q   <= duration_i;
      in_last_q  <= last_task_i;
    end
    if (emit_v && go) begin
      hold_id_q <= emit_id;
      hold_st_q <= emit_st;
    end
    if ((emit_v && go && hold_v_q) || flush) begin
      out_id_q   <= hold_id_q;
      out_st_q   <= hold_st_q;
      out_last_q <= flush;
    end
  end

  assign out_valid_o = out_v_q;
  assign done_id_o   = out_id_q;
  assign status_o    = out_st_q;
  assign run_last_o  = out_last_q;

endmodule

>>> rtl/core/lpts_checker.sv
// Port-level checks for the task scheduler, bound to its top level.
module lpts_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lpts_pkg::IdW-1:0]    done_id_o,
  input logic [lpts_pkg::StatW-1:0]  status_o,
  input logic                        run_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(done_id_o)
      && $stable(status_o) && $stable(run_last_o))
    else $error("stalled output transaction changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous task still in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == lpts_pkg::StatDone)
      || (status_o == lpts_pkg::StatOverflow) || (status_o == lpts_pkg::StatOrder))
    else $error("undefined status code");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> run_last_o)
    else $error("idle with a non-final result pending");

endmodule

bind lifo_preemptive_task_scheduler_top lpts_checker u_lpts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .done_id_o   (done_id_o),
  .status_o    (status_o),
  .run_last_o  (run_last_o)
);

>>> sim/tb_lifo_preemptive_task_scheduler_top.sv
// Self-checking testbench for the preemptive LIFO task scheduler top level.
module tb_lifo_preemptive_task_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lpts_pkg::*;

  localparam int STACK_DEPTH = 31;
  localparam int RAND_ITEMS  = 250;
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [StatW-1:0] stat;
    logic             tail;
  } done_t;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [IdW-1:0]    task_id_i      = '0;
  logic [StartW-1:0] start_minute_i = '0;
  logic [RemW-1:0]   duration_i     = '0;
  logic              last_task_i    = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [IdW-1:0]    done_id_o;
  logic [StatW-1:0]  status_o;
  logic              run_last_o;

  lifo_preemptive_task_scheduler_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .task_id_i     (task_id_i),
    .start_minute_i(start_minute_i),
    .duration_i    (duration_i),
    .last_task_i   (last_task_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .done_id_o     (done_id_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o)
  );

  // scheduler shadow state
  logic [IdW-1:0]    run_id    = '0;
  logic [RemW-1:0]   run_rem   = '0;
  logic              run_valid = 1'b0;
  logic [StartW-1:0] run_start = '0;
  entry_t            paused [STACK_DEPTH];
  int                paused_n  = 0;

  done_t completions_q [$];

  bit calm = 1'b0;
  int cycles = 0;
  int errors = 0;
  int tasks_sent = 0;
  int n_done = 0;
  int n_overflow = 0;
  int n_order = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i = calm ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d completions pending", cycles,
               completions_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic done_t make_done(logic [IdW-1:0] id, logic [StatW-1:0] stat);
    done_t r;
    r.id   = id;
    r.stat = stat;
    r.tail = 1'b0;
    return r;
  endfunction

  task automatic predict_schedule(input logic [IdW-1:0] id, input logic [StartW-1:0] start,
                                  input logic [RemW-1:0] dur, input logic is_last);
    done_t          batch [$];
    logic [EndW-1:0] fin;
    logic [EndW-1:0] gap;
    entry_t          top;
    if (run_valid && start < run_start) begin
      batch = {batch, make_done(id, StatOrder)};
    end else begin
      if (run_valid) begin
        fin = EndW'(run_start) + EndW'(run_rem);
        if (fin > EndW'(start)) begin
          if (paused_n >= STACK_DEPTH) begin
            batch = {batch, make_done(run_id, StatOverflow)};
          end else begin
            paused[paused_n].id  = run_id;
            paused[paused_n].rem = RemW'(fin - EndW'(start));
            paused_n++;
          end
        end else begin
          gap = EndW'(start) - fin;
          batch = {batch, make_done(run_id, StatDone)};
          while (paused_n > 0 && gap > 0) begin
            top = paused[paused_n-1];
            if (EndW'(top.rem) <= gap) begin
              gap = gap - EndW'(top.rem);
              batch = {batch, make_done(top.id, StatDone)};
              paused_n--;
            end else begin
              paused[paused_n-1].rem = RemW'(EndW'(top.rem) - gap);
              gap = '0;
            end
          end
        end
      end
      run_id    = id;
      run_start = start;
      run_rem   = dur;
      run_valid = 1'b1;
    end
    if (is_last) begin
      if (run_valid) batch = {batch, make_done(run_id, StatDone)};
      while (paused_n > 0) begin
        batch = {batch, make_done(paused[paused_n-1].id, StatDone)};
        paused_n--;
      end
      run_valid = 1'b0;
      run_id    = '0;
      run_rem   = '0;
      run_start = '0;
    end
    if (batch.size() > 0) batch[batch.size()-1].tail = 1'b1;
    foreach (batch[i]) completions_q = {completions_q, batch[i]};
  endtask

  always @(posedge clk_i) begin : check_completions
    done_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (completions_q.size() == 0) begin
        $error("unexpected transaction: done_id %0d status %0d run_last %0d",
               done_id_o, status_o, run_last_o);
        errors++;
      end else begin
        want = completions_q.pop_front();
        if (done_id_o !== want.id) begin
          $error("done_id mismatch: expected %0d, got %0d", want.id, done_id_o);
          errors++;
        end
        if (status_o !== want.stat) begin
          $error("status mismatch: expected %0d, got %0d", want.stat, status_o);
          errors++;
        end
        if (run_last_o !== want.tail) begin
          $error("run_last mismatch: expected %0d, got %0d", want.tail, run_last_o);
          errors++;
        end
        case (want.stat)
          StatOverflow: n_overflow++;
          StatOrder:    n_order++;
          default:      n_done++;
        endcase
      end
    end
  end

  task automatic send_task(input logic [IdW-1:0] id, input logic [StartW-1:0] start,
                           input logic [RemW-1:0] dur, input logic is_last);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 20 && gap < 8) gap++;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    task_id_i      = id;
    start_minute_i = start;
    duration_i     = dur;
    last_task_i    = is_last;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_schedule(id, start, dur, is_last);
    tasks_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (completions_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_basic_flow();
    send_task(10'd5,    11'd0,    12'd10,   1'b0);
    send_task(10'd6,    11'd3,    12'd4,    1'b0);
    send_task(10'd7,    11'd5,    12'd0,    1'b0);
    send_task(10'd8,    11'd20,   12'd1,    1'b0);
    send_task(10'd9,    11'd22,   12'd4095, 1'b0);
    send_task(10'd10,   11'd23,   12'd100,  1'b0);
    send_task(10'd11,   11'd124,  12'd5,    1'b0);
    settle();
    send_task(10'd1023, 11'd10,   12'd4095, 1'b0);
    send_task(10'd12,   11'd5,    12'd1,    1'b1);
    send_task(10'd0,    11'd1439, 12'd4095, 1'b1);
    send_task(10'd20,   11'd100,  12'd0,    1'b0);
    send_task(10'd21,   11'd100,  12'd0,    1'b0);
    send_task(10'd22,   11'd100,  12'd3,    1'b1);
    send_task(10'h2AA,  11'd1024, 12'h555,  1'b0);
    send_task(10'h155,  11'd1100, 12'hAAA,  1'b0);
    send_task(10'h3FF,  11'd1439, 12'd1,    1'b1);
    settle();
  endtask

  task automatic test_stack_overflow();
    for (int k = 0; k <= STACK_DEPTH + 1; k++) begin
      send_task(IdW'(100 + 29 * k), StartW'(k), 12'd4095, k == STACK_DEPTH + 1);
    end
    settle();
  endtask

  task automatic test_random_days();
    int                n;
    int                len;
    int                t;
    int                roll;
    bit                deep;
    bit                closed;
    logic [StartW-1:0] s;
    logic [RemW-1:0]   d;
    logic              is_last;
    n = 0;
    while (n < RAND_ITEMS) begin
      calm   = (n >= 120 && n < 180);
      deep   = ($urandom_range(0, 9) == 0);
      len    = deep ? $urandom_range(20, 40) : $urandom_range(1, 12);
      closed = ($urandom_range(0, 19) != 0);
      t      = $urandom_range(0, 200);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 4) begin
          s = StartW'($urandom_range(0, t));
        end else begin
          t += deep ? $urandom_range(0, 2) : $urandom_range(0, 40);
          if (t > 1439) t = 1439;
          s = StartW'(t);
        end
        roll = $urandom_range(0, 99);
        if (deep)           d = RemW'($urandom_range(1000, 4095));
        else if (roll < 5)  d = '0;
        else if (roll < 55) d = RemW'($urandom_range(1, 40));
        else if (roll < 80) d = RemW'($urandom_range(1, 400));
        else                d = RemW'($urandom_range(1, 4095));
        is_last = (closed && k == len - 1) || ($urandom_range(0, 49) == 0);
        send_task(IdW'($urandom_range(0, 1023)), s, d, is_last);
        n++;
      end
      if ($urandom_range(0, 7) == 0) settle();
    end
    calm = 1'b0;
    send_task(IdW'($urandom_range(0, 1023)), 11'd1439, 12'd1, 1'b1);
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_flow();
    test_stack_overflow();
    test_random_days();
    $display("%0d tasks sent: %0d completions, %0d overflow and %0d order transactions",
             tasks_sent, n_done, n_overflow, n_order);
    $display("covered preemption, LIFO resume, drains, overflow and out-of-order starts");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lpts_pkg.sv
rtl/core/lpts_stack_mem.sv
rtl/core/lifo_preemptive_task_scheduler_top.sv
rtl/core/lpts_checker.sv
sim/tb_lifo_preemptive_task_scheduler_top.sv
